>>> src/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg
// Shared constants for the segment intersection point pipeline.
// ----------------------------------------------------------------------------
package sip_pkg;

    // Default coordinate width of the input ports
    localparam int COORD_WIDTH_DEF = 16;

    // Coordinates are sign-extended from at most this many bits
    localparam int EFF_MAX = 20;

    // Width of the intersection point outputs
    localparam int OUT_W = 17;

endpackage

>>> src/sip_div.sv
// ----------------------------------------------------------------------------
// sip_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// The caller guarantees num < den * 2**Q_W.
// ----------------------------------------------------------------------------
module sip_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32,
    parameter int Q_W   = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             out_valid,
    output logic [Q_W-1:0]   quot
);

    localparam int TW = (DEN_W + Q_W > NUM_W) ? DEN_W + Q_W : NUM_W;

    logic [TW-1:0]    rem_reg  [Q_W];
    logic [DEN_W-1:0] den_reg  [Q_W];
    logic [Q_W-1:0]   quot_reg [Q_W];
    logic [Q_W-1:0]   valid_reg;

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [TW-1:0]    rem_src;
        logic [DEN_W-1:0] den_src;
        logic [Q_W-1:0]   quot_src;
        logic             valid_src;
        logic [TW-1:0]    trial;
        logic             take;

        if (k == 0) begin : g_first
            assign rem_src   = TW'(num);
            assign den_src   = den;
            assign quot_src  = '0;
            assign valid_src = in_valid;
        end
        else begin : g_rest
            assign rem_src   = rem_reg[k-1];
            assign den_src   = den_reg[k-1];
            assign quot_src  = quot_reg[k-1];
            assign valid_src = valid_reg[k-1];
        end

        // bit Q_W-1-k of the quotient
        assign trial = TW'(den_src) << (Q_W - 1 - k);
        assign take  = (rem_src >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_src;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= take ? (rem_src - trial) : rem_src;
            den_reg[k]  <= den_src;
            quot_reg[k] <= {quot_src[Q_W-2:0], take};
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign quot      = quot_reg[Q_W-1];

endmodule

>>> src/segment_intersection_point.sv
// ----------------------------------------------------------------------------
// segment_intersection_point
// Intersection of two 2D segments (start + direction, signed Q12.4).
//
//   channel  | handshake      | payload
//   ---------+----------------+-----------------------------------------------
//   request  | start / busy   | seg_a_*, seg_b_* (start and direction, x/y)
//   result   | done (strobe)  | hit, cross_x, cross_y
//
// One request enters per cycle; busy is always low. The result strobe is
// produced through six front stages, EW one-bit-per-stage divider stages
// (EW = min(COORD_WIDTH, 20)) and the output register, in that order, the
// first front stage loading at the accepting edge. Reset clears the valid
// bits of every stage; payload is not reset. The receiver cannot stall, so
// the pipeline never holds.
// ----------------------------------------------------------------------------
module segment_intersection_point #(
    parameter int COORD_WIDTH = sip_pkg::COORD_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [COORD_WIDTH-1:0]             seg_a_start_x,
    input  logic [COORD_WIDTH-1:0]             seg_a_start_y,
    input  logic [COORD_WIDTH-1:0]             seg_a_dir_x,
    input  logic [COORD_WIDTH-1:0]             seg_a_dir_y,
    input  logic [COORD_WIDTH-1:0]             seg_b_start_x,
    input  logic [COORD_WIDTH-1:0]             seg_b_start_y,
    input  logic [COORD_WIDTH-1:0]             seg_b_dir_x,
    input  logic [COORD_WIDTH-1:0]             seg_b_dir_y,
    output logic                               done,
    output logic                               hit,
    output logic signed [sip_pkg::OUT_W-1:0]   cross_x,
    output logic signed [sip_pkg::OUT_W-1:0]   cross_y
);

    import sip_pkg::*;

    localparam int EW    = (COORD_WIDTH > EFF_MAX) ? EFF_MAX : COORD_WIDTH;
    localparam int P_W   = 2 * EW + 1;   // products
    localparam int C_W   = 2 * EW + 2;   // cross products
    localparam int M_W   = 2 * EW;       // magnitude of cross
    localparam int N_W   = 3 * EW;       // dividend
    localparam int S_W   = EW + 2;       // point sum
    localparam int X_W   = (S_W > OUT_W) ? S_W : OUT_W;

    typedef struct packed {
        logic                 hit;
        logic                 neg_x;
        logic                 neg_y;
        logic signed [EW-1:0] ax;
        logic signed [EW-1:0] ay;
    } side_t;

    assign busy = 1'b0;

    // ---------------- stage 1: capture, start-to-start vector ----------------
    logic                 v1_reg;
    logic signed [EW-1:0] ax1_reg, ay1_reg, adx1_reg, ady1_reg, bdx1_reg, bdy1_reg;
    logic signed [EW:0]   sx1_reg, sy1_reg;
    logic signed [EW:0]   sx1_next, sy1_next;

    assign sx1_next = signed'({seg_b_start_x[EW-1], seg_b_start_x[EW-1:0]})
                    - signed'({seg_a_start_x[EW-1], seg_a_start_x[EW-1:0]});
    assign sy1_next = signed'({seg_b_start_y[EW-1], seg_b_start_y[EW-1:0]})
                    - signed'({seg_a_start_y[EW-1], seg_a_start_y[EW-1:0]});

    // ---------------- stage 2: six products ----------------------------------
    logic                 v2_reg;
    logic signed [P_W-1:0] m_ab2_reg, m_ba2_reg;      // adx*bdy, ady*bdx
    logic signed [P_W-1:0] m_sa2_reg, m_ta2_reg;      // sx*ady, sy*adx
    logic signed [P_W-1:0] m_sb2_reg, m_tb2_reg;      // sx*bdy, sy*bdx
    logic signed [EW-1:0]  ax2_reg, ay2_reg, adx2_reg, ady2_reg;

    // ---------------- stage 3: cross products --------------------------------
    logic                  v3_reg;
    logic signed [C_W-1:0] c3_reg, ca3_reg, cb3_reg;
    logic signed [EW-1:0]  ax3_reg, ay3_reg, adx3_reg, ady3_reg;

    // ---------------- stage 4: decision, magnitudes --------------------------
    logic                  v4_reg;
    side_t                 side4_reg;
    logic [M_W-1:0]        cmag4_reg, cbmag4_reg;
    logic [EW:0]           amx4_reg, amy4_reg;    // most negative needs EW+1 bits

    logic                  hit4_next;
    logic                  ok_b, ok_a;
    logic [C_W-1:0]        c_abs, cb_abs;
    logic [EW:0]           adx_abs, ady_abs;

    always_comb
    begin
        if (!c3_reg[C_W-1])
        begin
            ok_b = !cb3_reg[C_W-1] && (cb3_reg <= c3_reg);
            ok_a = !ca3_reg[C_W-1] && (ca3_reg <= c3_reg);
        end
        else
        begin
            ok_b = (cb3_reg <= 0) && (cb3_reg >= c3_reg);
            ok_a = (ca3_reg <= 0) && (ca3_reg >= c3_reg);
        end
        hit4_next = (c3_reg != 0) && ok_a && ok_b;
        c_abs     = c3_reg[C_W-1]  ? C_W'(-c3_reg)  : C_W'(c3_reg);
        cb_abs    = cb3_reg[C_W-1] ? C_W'(-cb3_reg) : C_W'(cb3_reg);
        adx_abs   = adx3_reg[EW-1] ? (EW+1)'(-(EW+1)'(adx3_reg)) : (EW+1)'(adx3_reg);
        ady_abs   = ady3_reg[EW-1] ? (EW+1)'(-(EW+1)'(ady3_reg)) : (EW+1)'(ady3_reg);
    end

    // ---------------- stage 5: partial products ------------------------------
    logic                  v5_reg;
    side_t                 side5_reg;
    logic [M_W-1:0]        cmag5_reg;
    logic [M_W-1:0]        plx5_reg, phx5_reg, ply5_reg, phy5_reg;

    // ---------------- stage 6: dividends -------------------------------------
    logic                  v6_reg;
    side_t                 side6_reg;
    logic [M_W-1:0]        cmag6_reg;
    logic [N_W-1:0]        numx6_reg, numy6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1
        ax1_reg  <= signed'(seg_a_start_x[EW-1:0]);
        ay1_reg  <= signed'(seg_a_start_y[EW-1:0]);
        adx1_reg <= signed'(seg_a_dir_x[EW-1:0]);
        ady1_reg <= signed'(seg_a_dir_y[EW-1:0]);
        bdx1_reg <= signed'(seg_b_dir_x[EW-1:0]);
        bdy1_reg <= signed'(seg_b_dir_y[EW-1:0]);
        sx1_reg  <= sx1_next;
        sy1_reg  <= sy1_next;

        // stage 2
        m_ab2_reg <= P_W'(adx1_reg) * P_W'(bdy1_reg);
        m_ba2_reg <= P_W'(ady1_reg) * P_W'(bdx1_reg);
        m_sa2_reg <= P_W'(sx1_reg) * P_W'(ady1_reg);
        m_ta2_reg <= P_W'(sy1_reg) * P_W'(adx1_reg);
        m_sb2_reg <= P_W'(sx1_reg) * P_W'(bdy1_reg);
        m_tb2_reg <= P_W'(sy1_reg) * P_W'(bdx1_reg);
        ax2_reg   <= ax1_reg;
        ay2_reg   <= ay1_reg;
        adx2_reg  <= adx1_reg;
        ady2_reg  <= ady1_reg;

        // stage 3
        c3_reg   <= C_W'(m_ab2_reg) - C_W'(m_ba2_reg);
        ca3_reg  <= C_W'(m_sa2_reg) - C_W'(m_ta2_reg);
        cb3_reg  <= C_W'(m_sb2_reg) - C_W'(m_tb2_reg);
        ax3_reg  <= ax2_reg;
        ay3_reg  <= ay2_reg;
        adx3_reg <= adx2_reg;
        ady3_reg <= ady2_reg;

        // stage 4: on a hit |cb| <= |c| < 2**M_W, so the cut is exact
        side4_reg.hit   <= hit4_next;
        side4_reg.neg_x <= adx3_reg[EW-1] ^ cb3_reg[C_W-1] ^ c3_reg[C_W-1];
        side4_reg.neg_y <= ady3_reg[EW-1] ^ cb3_reg[C_W-1] ^ c3_reg[C_W-1];
        side4_reg.ax    <= ax3_reg;
        side4_reg.ay    <= ay3_reg;
        cmag4_reg       <= c_abs[M_W-1:0];
        cbmag4_reg      <= cb_abs[M_W-1:0];
        amx4_reg        <= adx_abs;
        amy4_reg        <= ady_abs;

        // stage 5
        side5_reg <= side4_reg;
        cmag5_reg <= cmag4_reg;
        plx5_reg  <= M_W'(amx4_reg) * M_W'(cbmag4_reg[EW-1:0]);
        phx5_reg  <= M_W'(amx4_reg) * M_W'(cbmag4_reg[M_W-1:EW]);
        ply5_reg  <= M_W'(amy4_reg) * M_W'(cbmag4_reg[EW-1:0]);
        phy5_reg  <= M_W'(amy4_reg) * M_W'(cbmag4_reg[M_W-1:EW]);

        // stage 6
        side6_reg <= side5_reg;
        cmag6_reg <= cmag5_reg;
        numx6_reg <= (N_W'(phx5_reg) << EW) + N_W'(plx5_reg);
        numy6_reg <= (N_W'(phy5_reg) << EW) + N_W'(ply5_reg);
    end

    // ---------------- divider stages ----------------------------------------
    logic          dvx, dvy;
    logic [EW-1:0] qx, qy;

    sip_div #(
        .NUM_W (N_W),
        .DEN_W (M_W),
        .Q_W   (EW)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .num       (numx6_reg),
        .den       (cmag6_reg),
        .out_valid (dvx),
        .quot      (qx)
    );

    sip_div #(
        .NUM_W (N_W),
        .DEN_W (M_W),
        .Q_W   (EW)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .num       (numy6_reg),
        .den       (cmag6_reg),
        .out_valid (dvy),
        .quot      (qy)
    );

    // sideband rides alongside the dividers
    side_t side_reg [EW];

    for (genvar k = 0; k < EW; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (k == 0)
            begin
                side_reg[k] <= side6_reg;
            end
            else
            begin
                side_reg[k] <= side_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    side_t                side_last;
    logic signed [EW:0]   sqx, sqy;
    logic signed [S_W-1:0] sum_x, sum_y;
    logic signed [X_W-1:0] wide_x, wide_y;

    assign side_last = side_reg[EW-1];

    always_comb
    begin
        sqx    = side_last.neg_x ? -signed'({1'b0, qx}) : signed'({1'b0, qx});
        sqy    = side_last.neg_y ? -signed'({1'b0, qy}) : signed'({1'b0, qy});
        sum_x  = S_W'(side_last.ax) + S_W'(sqx);
        sum_y  = S_W'(side_last.ay) + S_W'(sqy);
        wide_x = X_W'(sum_x);
        wide_y = X_W'(sum_y);
    end

    // ---------------- output register ---------------------------------------
    logic                         done_reg, hit_reg;
    logic signed [OUT_W-1:0]      cross_x_reg, cross_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= dvx;
            hit_reg  <= dvx && side_last.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        cross_x_reg <= side_last.hit ? wide_x[OUT_W-1:0] : '0;
        cross_y_reg <= side_last.hit ? wide_y[OUT_W-1:0] : '0;
    end

    assign done    = done_reg;
    assign hit     = hit_reg;
    assign cross_x = cross_x_reg;
    assign cross_y = cross_y_reg;

    // ---------------- assertions --------------------------------------------
    localparam logic [EW-1:0] Q_MAX = {1'b1, {(EW-1){1'b0}}};

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> cross_x == 0 && cross_y == 0)
        else $error("miss result carries a nonzero point");

    a_hit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> done)
        else $error("hit raised without result strobe");

    a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
        dvx == dvy)
        else $error("x and y dividers out of step");

    a_hit_nonpar: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && side4_reg.hit |-> cmag4_reg != 0)
        else $error("hit decided for parallel directions");

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dvx && side_last.hit |-> qx <= Q_MAX && qy <= Q_MAX)
        else $error("quotient exceeds direction magnitude");

endmodule

>>> tb/segment_intersection_point_test.sv
// ----------------------------------------------------------------------------
// segment_intersection_point_test
// Self-checking bench for the segment intersection point pipeline. A table
// of hand-picked segment pairs comes first: parallel, collinear, endpoint
// and coordinate extreme cases. Random pairs follow. Every request is
// predicted at its acceptance, and every strobed result is compared in
// order against the oldest prediction.
// ----------------------------------------------------------------------------
module segment_intersection_point_test;

    localparam int CW = sip_pkg::COORD_WIDTH_DEF;
    localparam int OW = sip_pkg::OUT_W;
    localparam int RANDOM_PAIRS = 600;
    localparam int DRAIN_AT = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    localparam logic signed [CW-1:0] C_MIN = 16'sh8000;
    localparam logic signed [CW-1:0] C_MAX = 16'sh7fff;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] adx;
        logic signed [CW-1:0] ady;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] bdx;
        logic signed [CW-1:0] bdy;
    } seg_pair_t;

    typedef struct packed {
        logic                 hit;
        logic signed [OW-1:0] px;
        logic signed [OW-1:0] py;
    } point_t;

    typedef struct packed {
        seg_pair_t pair;
        logic      typed;
        point_t    want;
    } directed_row_t;

    localparam point_t NO_HIT = '{1'b0, 17'sd0, 17'sd0};

    localparam int N_DIRECTED = 21;

    // typed = 1: expected point given in the row, else from the predictor
    localparam directed_row_t DIRECTED_PAIRS [N_DIRECTED] = '{
        // all zero, degenerate directions
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
          1'b1, NO_HIT},
        // parallel, same sense
        '{'{16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16, 16'sd32, 16'sd0},
          1'b1, NO_HIT},
        // antiparallel
        '{'{16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'sd32, 16'sd0, -16'sd16, -16'sd16},
          1'b1, NO_HIT},
        // collinear overlap still reports no hit
        '{'{16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd16, 16'sd0, 16'sd16, 16'sd0},
          1'b1, NO_HIT},
        // zero-length first segment
        '{'{16'sd5, 16'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16, 16'sd16},
          1'b1, NO_HIT},
        // crossing at both midpoints
        '{'{16'sd0, 16'sd0, 16'sd32, 16'sd0, 16'sd16, -16'sd16, 16'sd0, 16'sd32},
          1'b1, '{1'b1, 17'sd16, 17'sd0}},
        // shared start point
        '{'{16'sd0, 16'sd0, 16'sd32, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32},
          1'b1, '{1'b1, 17'sd0, 17'sd0}},
        // touching the end of the first segment
        '{'{16'sd0, 16'sd0, 16'sd32, 16'sd0, 16'sd32, -16'sd16, 16'sd0, 16'sd32},
          1'b1, '{1'b1, 17'sd32, 17'sd0}},
        // one LSB past the end of the first segment
        '{'{16'sd0, 16'sd0, 16'sd32, 16'sd0, 16'sd33, -16'sd16, 16'sd0, 16'sd32},
          1'b1, NO_HIT},
        // second segment lies beyond its start side
        '{'{16'sd0, 16'sd0, 16'sd32, 16'sd0, 16'sd16, 16'sd16, 16'sd0, 16'sd32},
          1'b1, NO_HIT},
        // first segment parameter just below zero
        '{'{16'sd0, 16'sd0, 16'sd32, 16'sd0, -16'sd1, -16'sd16, 16'sd0, 16'sd32},
          1'b1, NO_HIT},
        // second segment one LSB short
        '{'{16'sd0, 16'sd0, 16'sd32, 16'sd0, 16'sd16, -16'sd33, 16'sd0, 16'sd32},
          1'b1, NO_HIT},
        // negative direction cross product
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd32, -16'sd16, 16'sd16, 16'sd32, 16'sd0},
          1'b0, NO_HIT},
        // quotients that truncate
        '{'{16'sd0, 16'sd0, 16'sd7, 16'sd3, 16'sd2, -16'sd5, -16'sd1, 16'sd9},
          1'b0, NO_HIT},
        '{'{16'sd0, 16'sd0, -16'sd7, 16'sd5, -16'sd3, -16'sd1, 16'sd2, 16'sd3},
          1'b0, NO_HIT},
        // both ends meet at the positive corner, point needs the 17th bit
        '{'{C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX},
          1'b1, '{1'b1, 17'sd65534, -17'sd1}},
        // both ends meet at the most negative corner
        '{'{C_MIN, C_MIN, C_MIN, 16'sd0, C_MIN, 16'sd0, C_MIN, C_MIN},
          1'b1, '{1'b1, 17'sh10000, -17'sd32768}},
        '{'{C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX},
          1'b0, NO_HIT},
        '{'{C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN},
          1'b0, NO_HIT},
        // largest directions, parallel
        '{'{C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN},
          1'b1, NO_HIT},
        '{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd2, 16'sd1, -16'sd1},
          1'b0, NO_HIT}
    };

    localparam int SCALES [4] = '{15, 255, 4095, 8191};

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    seg_pair_t drive_pair;
    logic      done;
    logic      hit;
    logic signed [OW-1:0] cross_x;
    logic signed [OW-1:0] cross_y;

    point_t pending_points [$];
    point_t oldest_point;
    int     error_count = 0;
    int     calm_left = 0;

    segment_intersection_point dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .seg_a_start_x (drive_pair.ax),
        .seg_a_start_y (drive_pair.ay),
        .seg_a_dir_x   (drive_pair.adx),
        .seg_a_dir_y   (drive_pair.ady),
        .seg_b_start_x (drive_pair.bx),
        .seg_b_start_y (drive_pair.by),
        .seg_b_dir_x   (drive_pair.bdx),
        .seg_b_dir_y   (drive_pair.bdy),
        .done          (done),
        .hit           (hit),
        .cross_x       (cross_x),
        .cross_y       (cross_y)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // num/den within [0,1], den nonzero
    function automatic bit in_unit_span(longint num, longint den);
        if (den > 0)
            return num >= 0 && num <= den;
        return num <= 0 && num >= den;
    endfunction

    function automatic point_t intersect_point(seg_pair_t p);
        longint ax, ay, adx, ady, bx, by, bdx, bdy;
        longint den, num_a, num_b, sx, sy, px_full, py_full;
        point_t r;
        r = NO_HIT;
        ax = $signed(p.ax);
        ay = $signed(p.ay);
        adx = $signed(p.adx);
        ady = $signed(p.ady);
        bx = $signed(p.bx);
        by = $signed(p.by);
        bdx = $signed(p.bdx);
        bdy = $signed(p.bdy);
        den = adx * bdy - ady * bdx;
        if (den == 0)
            return r;
        sx = bx - ax;
        sy = by - ay;
        num_a = sx * ady - sy * adx;
        num_b = sx * bdy - sy * bdx;
        if (!in_unit_span(num_b, den) || !in_unit_span(num_a, den))
            return r;
        // signed division truncates toward zero
        px_full = ax + (adx * num_b) / den;
        py_full = ay + (ady * num_b) / den;
        r.hit = 1'b1;
        r.px = px_full[OW-1:0];
        r.py = py_full[OW-1:0];
        return r;
    endfunction

    function automatic logic signed [CW-1:0] to_coord(int v);
        return v[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] pick_coord(int lim);
        return to_coord(int'($urandom_range(0, 2 * lim + 1)) - lim - 1);
    endfunction

    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        int mode;
        int lim;
        int k;
        mode = $urandom_range(0, 9);
        lim = (mode < 2) ? 32767 : SCALES[$urandom_range(0, 3)];
        p.ax = pick_coord(lim);
        p.ay = pick_coord(lim);
        p.adx = pick_coord(lim);
        p.ady = pick_coord(lim);
        p.bx = pick_coord(lim);
        p.by = pick_coord(lim);
        p.bdx = pick_coord(lim);
        p.bdy = pick_coord(lim);
        if (mode == 6 || mode == 7)
        begin
            // parallel directions; mode 7 also puts B on the line of A
            k = int'($urandom_range(0, 6)) - 3;
            p.bdx = to_coord(k * int'(p.adx));
            p.bdy = to_coord(k * int'(p.ady));
            if (mode == 7)
            begin
                k = int'($urandom_range(0, 4)) - 2;
                p.bx = to_coord(int'(p.ax) + k * int'(p.adx));
                p.by = to_coord(int'(p.ay) + k * int'(p.ady));
            end
        end
        else if (mode >= 8)
        begin
            // endpoints touching: parameters land exactly on 0 or 1
            case ($urandom_range(0, 2))
                0:
                begin
                    p.bx = p.ax;
                    p.by = p.ay;
                end
                1:
                begin
                    p.bx = to_coord(int'(p.ax) + int'(p.adx));
                    p.by = to_coord(int'(p.ay) + int'(p.ady));
                end
                default:
                begin
                    p.bx = to_coord(int'(p.ax) + int'(p.adx) - int'(p.bdx));
                    p.by = to_coord(int'(p.ay) + int'(p.ady) - int'(p.bdy));
                end
            endcase
        end
        return p;
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic send_pair(input seg_pair_t p, input point_t want);
        int gap;
        if (calm_left == 0 && $urandom_range(0, 3) == 0)
            calm_left = $urandom_range(10, 40);
        if (calm_left > 0)
        begin
            calm_left--;
            gap = 0;
        end
        else
            gap = $urandom_range(0, 11);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        drive_pair <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_points.push_back(want);
    endtask

    // results cannot be held off: check every strobe as it passes
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_points.size() == 0)
                note_failure($sformatf("result with no request pending: hit=%b x=%0d y=%0d",
                                       hit, cross_x, cross_y));
            else
            begin
                oldest_point = pending_points.pop_front();
                if (hit !== oldest_point.hit || cross_x !== oldest_point.px ||
                    cross_y !== oldest_point.py)
                    note_failure($sformatf(
                        "mismatch: expected hit=%b x=%0d y=%0d, got hit=%b x=%0d y=%0d",
                        oldest_point.hit, oldest_point.px, oldest_point.py,
                        hit, cross_x, cross_y));
            end
        end
    end

    initial
    begin
        seg_pair_t p;
        rst_n = 1'b0;
        start = 1'b0;
        drive_pair = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            p = DIRECTED_PAIRS[i].pair;
            send_pair(p, DIRECTED_PAIRS[i].typed ? DIRECTED_PAIRS[i].want
                                                 : intersect_point(p));
        end

        for (int n = 0; n < RANDOM_PAIRS; n++)
        begin
            if (n == DRAIN_AT)
            begin
                // hold requests until the pipeline has emptied
                start <= 1'b0;
                @(posedge clk);
                while (pending_points.size() != 0)
                    @(posedge clk);
            end
            p = random_pair();
            send_pair(p, intersect_point(p));
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
